### rtl/core/riff_wave_chunk_parser_unit_assert.svh
// assertion macros shared by the rtl of the riff wave chunk parser unit
`ifndef RIFF_WAVE_CHUNK_PARSER_UNIT_ASSERT_SVH
`define RIFF_WAVE_CHUNK_PARSER_UNIT_ASSERT_SVH

// checked on every clock edge outside reset
`define RWCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define RWCP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/rwcp_pkg.sv
// ----------------------------------------------------------------------------
// rwcp_pkg
// Types and constants of the riff wave chunk parser unit.
// ----------------------------------------------------------------------------
package rwcp_pkg;

  typedef enum logic [1:0] {
    KindRiff    = 2'd0,
    KindFmt     = 2'd1,
    KindData    = 2'd2,
    KindUnknown = 2'd3
  } chunk_kind_e;

  // chunk ids, first byte in the low bits
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [31:0] FmtFieldBytes = 32'd16;

  typedef struct packed {
    chunk_kind_e kind;
    logic [31:0] tag;
    logic [31:0] length;
    logic [31:0] form;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
  } result_t;

endpackage

### rtl/core/rwcp_parse.sv
// ----------------------------------------------------------------------------
// rwcp_parse
// Byte-serial chunk parser: state, shift registers and result decode.
// ----------------------------------------------------------------------------
`include "riff_wave_chunk_parser_unit_assert.svh"

module rwcp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_in_i,
  output logic              res_valid_o,
  output rwcp_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PhId   = 3'd0,
    PhSize = 3'd1,
    PhForm = 3'd2,
    PhFmt  = 3'd3,
    PhSkip = 3'd4,
    PhDone = 3'd5
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [4:0]   idx_q, idx_d, idx_inc;
  logic [31:0]  tag_q, tag_d;
  logic [31:0]  len_q, len_d;
  logic [31:0]  skip_q, skip_d, skip_dec;
  logic [127:0] store_q, store_d;
  logic [6:0]   bit_pos;

  assign idx_inc  = idx_q + 5'd1;
  assign skip_dec = (skip_q != 32'd0) ? (skip_q - 32'd1) : skip_q;

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    tag_d       = tag_q;
    len_d       = len_q;
    skip_d      = skip_q;
    store_d     = store_q;
    bit_pos     = {idx_q[3:0], 3'b000};
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      case (phase_q)
        PhId: begin
          tag_d = {byte_in_i, tag_q[31:8]};
          idx_d = idx_inc;
          if (idx_inc >= 5'd4) begin
            idx_d   = '0;
            phase_d = PhSize;
          end
        end
        PhSize: begin
          len_d = {byte_in_i, len_q[31:8]};
          idx_d = idx_inc;
          if (idx_inc >= 5'd4) begin
            idx_d   = '0;
            store_d = '0;
            if (tag_q == rwcp_pkg::TagRiff) begin
              phase_d = PhForm;
            end else if (tag_q == rwcp_pkg::TagFmt) begin
              phase_d = PhFmt;
            end else begin
              res_valid_o  = 1'b1;
              res_o.tag    = tag_q;
              res_o.length = len_d;
              if (tag_q == rwcp_pkg::TagData) begin
                res_o.kind = rwcp_pkg::KindData;
                phase_d    = PhDone;
              end else begin
                res_o.kind = rwcp_pkg::KindUnknown;
                skip_d     = len_d;
                phase_d    = (len_d != 32'd0) ? PhSkip : PhId;
              end
            end
          end
        end
        PhForm: begin
          bit_pos = {2'b00, idx_q[1:0], 3'b000};
          store_d[bit_pos +: 8] = store_q[bit_pos +: 8] | byte_in_i;
          idx_d = idx_inc;
          if (idx_inc >= 5'd4) begin
            idx_d        = '0;
            res_valid_o  = 1'b1;
            res_o.kind   = rwcp_pkg::KindRiff;
            res_o.tag    = tag_q;
            res_o.length = len_q;
            res_o.form   = store_d[31:0];
            phase_d      = PhId;
          end
        end
        PhFmt: begin
          store_d[bit_pos +: 8] = store_q[bit_pos +: 8] | byte_in_i;
          idx_d = idx_inc;
          if (idx_inc >= 5'd16) begin
            idx_d               = '0;
            res_valid_o         = 1'b1;
            res_o.kind          = rwcp_pkg::KindFmt;
            res_o.tag           = tag_q;
            res_o.length        = len_q;
            res_o.format_code   = store_d[15:0];
            res_o.channel_count = store_d[31:16];
            res_o.sample_rate   = store_d[63:32];
            res_o.byte_rate     = store_d[95:64];
            res_o.block_align   = store_d[111:96];
            res_o.sample_bits   = store_d[127:112];
            if (len_q > rwcp_pkg::FmtFieldBytes) begin
              skip_d  = len_q - rwcp_pkg::FmtFieldBytes;
              phase_d = PhSkip;
            end else begin
              skip_d  = '0;
              phase_d = PhId;
            end
          end
        end
        PhSkip: begin
          skip_d = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_d = PhId;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhId;
      idx_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      skip_q  <= '0;
      store_q <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      store_q <= store_d;
    end
  end

  `RWCP_ASSERT(a_done_sticks, (phase_q == PhDone) |=> (phase_q == PhDone), "left done phase")
  `RWCP_ASSERT_ALWAYS(a_res_needs_accept, res_valid_o |-> accept_i, "result without transaction")
  `RWCP_ASSERT(a_idx_range, (idx_q < 5'd16), "byte index out of range")

endmodule

### rtl/core/rwcp_out_stage.sv
// ----------------------------------------------------------------------------
// rwcp_out_stage
// Output register with one skid entry between parser and result channel.
// ----------------------------------------------------------------------------
`include "riff_wave_chunk_parser_unit_assert.svh"

module rwcp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rwcp_pkg::result_t push_data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rwcp_pkg::result_t out_data_o
);

  logic              out_valid_q, skid_valid_q;
  rwcp_pkg::result_t out_data_q, skid_data_q;
  logic              pop;

  assign pop         = out_valid_q && out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_data_q <= skid_valid_q ? skid_data_q : push_data_i;
    end else if (push_i) begin
      skid_data_q <= push_data_i;
    end
  end

  `RWCP_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full, output empty")
  `RWCP_ASSERT(a_skid_drains, (out_valid_q && out_ready_i && skid_valid_q) |=> out_valid_q,
    "skid entry lost")
  `RWCP_ASSERT(a_skid_fill_on_stall,
    (skid_valid_q && !$past(skid_valid_q)) |-> ($past(out_valid_q) && !$past(out_ready_i)),
    "skid filled without stall")

endmodule

### rtl/core/riff_wave_chunk_parser_unit.sv
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser_unit
// Byte-serial WAV header parser reporting one result per chunk header.
// ----------------------------------------------------------------------------
//  channel | signals                           | direction
//  input   | in_valid_i, in_ready_o, byte_in_i | one file byte per transaction
//  output  | out_valid_o, out_ready_i, chunk_* | one chunk header per transaction
//
//  one byte is taken per cycle while in_ready_o is high; the parser state
//  updates in that cycle and any result is registered in the output stage.
//  reset returns the parser to expecting a chunk id, with no result pending.
//  the output register plus one skid entry absorb a stall; input is held
//  off only while the skid entry is occupied.
// ----------------------------------------------------------------------------
module riff_wave_chunk_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  chunk_kind_o,
  output logic [31:0] chunk_tag_o,
  output logic [31:0] chunk_length_o,
  output logic [31:0] form_tag_o,
  output logic [15:0] format_code_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [31:0] byte_rate_o,
  output logic [15:0] block_align_o,
  output logic [15:0] sample_bits_o
);

  logic              accept, res_valid, space;
  rwcp_pkg::result_t res, out_data;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  rwcp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_in_i   (byte_in_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rwcp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign chunk_kind_o    = out_data.kind;
  assign chunk_tag_o     = out_data.tag;
  assign chunk_length_o  = out_data.length;
  assign form_tag_o      = out_data.form;
  assign format_code_o   = out_data.format_code;
  assign channel_count_o = out_data.channel_count;
  assign sample_rate_o   = out_data.sample_rate;
  assign byte_rate_o     = out_data.byte_rate;
  assign block_align_o   = out_data.block_align;
  assign sample_bits_o   = out_data.sample_bits;

endmodule
